// ===== hw/rtl/tbd_pkg.sv =====
// Shared types and constants for the tracking block deframer.
package tbd_pkg;

  localparam logic [3:0] HDR_TOP_NIB = 4'hA;
  localparam logic [3:0] HDR_MID_NIB = 4'hC;
  localparam logic [2:0] LAST_PHASE  = 3'd6;
  localparam int         HELD_WORDS  = 6;
  localparam int         CNT_W       = 11;
  localparam int         CNT_FIELD_MAX = 2047;
  localparam int         QUEUE_DEPTH = 2;
  localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int         OUT_DATA_W  = 288;

  typedef struct packed {
    logic [31:0] bx_word;
    logic [15:0] block_crc;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
    logic [11:0] chip_id;
    logic [3:0]  block_flags;
    logic [7:0]  event_number;
    logic [11:0] bunch_crossing;
  } blk_t;

  typedef struct packed {
    blk_t             blk;
    logic             new_event;
    logic [31:0]      event_total;
    logic [31:0]      block_total;
    logic [CNT_W-1:0] blocks_in_event;
  } res_t;

endpackage

// ===== hw/rtl/tbd_front.sv =====
// Front end: header hunt and seven-word block assembly.
module tbd_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        q_full,
  output logic        q_push,
  output tbd_pkg::blk_t q_blk
);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] held_r [tbd_pkg::HELD_WORDS];
  logic        accept;
  logic        hunting;
  logic        hdr_ok;

  assign hunting   = (phase_r == 3'd0) || (phase_r > tbd_pkg::LAST_PHASE);
  assign hdr_ok    = (in_tdata[31:28] == tbd_pkg::HDR_TOP_NIB) &&
                     (in_tdata[15:12] == tbd_pkg::HDR_MID_NIB);
  assign in_tready = (phase_r != tbd_pkg::LAST_PHASE) || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && (phase_r == tbd_pkg::LAST_PHASE);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (hunting) begin
        phase_nxt = hdr_ok ? 3'd1 : 3'd0;
      end else if (phase_r < tbd_pkg::LAST_PHASE) begin
        phase_nxt = phase_r + 3'd1;
      end else begin
        phase_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (hunting) begin
        if (hdr_ok) begin
          held_r[0] <= in_tdata;
        end
      end else if (phase_r < tbd_pkg::LAST_PHASE) begin
        held_r[phase_r] <= in_tdata;
      end
    end
  end

  always_comb begin
    q_blk.bunch_crossing = held_r[0][27:16];
    q_blk.event_number   = held_r[0][11:4];
    q_blk.block_flags    = held_r[0][3:0];
    q_blk.chip_id        = held_r[1][27:16];
    q_blk.payload_high   = {held_r[1][15:0], held_r[2], held_r[3][31:16]};
    q_blk.payload_low    = {held_r[3][15:0], held_r[4], held_r[5][31:16]};
    q_blk.block_crc      = held_r[5][15:0];
    q_blk.bx_word        = in_tdata;
  end

endmodule

// ===== hw/rtl/tbd_queue.sv =====
// Short queue of assembled blocks between front and back ends.
module tbd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tbd_pkg::blk_t push_blk,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output tbd_pkg::blk_t pop_blk
);

  localparam int PW = tbd_pkg::QPTR_W;
  localparam int CW = $clog2(tbd_pkg::QUEUE_DEPTH + 1);

  tbd_pkg::blk_t entry_r [tbd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(tbd_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_blk   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(tbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(tbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_blk;
    end
  end

endmodule

// ===== hw/rtl/tbd_back.sv =====
// Back end: event tracking, counters and the output register.
module tbd_back #(
  parameter int MAX_BLOCKS_PER_EVENT = 1023
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  tbd_pkg::blk_t q_blk,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output tbd_pkg::res_t out_res
);

  localparam int LIM_RAW = MAX_BLOCKS_PER_EVENT + 1;
  localparam int LIM_SAT = (LIM_RAW > tbd_pkg::CNT_FIELD_MAX) ?
                           tbd_pkg::CNT_FIELD_MAX : LIM_RAW;
  localparam logic [tbd_pkg::CNT_W-1:0] LIMIT = tbd_pkg::CNT_W'(LIM_SAT);

  logic [19:0]               sel_r, sel;
  logic                      sel_valid_r;
  logic [31:0]               evt_cnt_r, evt_cnt_nxt;
  logic [31:0]               blk_cnt_r, blk_cnt_nxt;
  logic [tbd_pkg::CNT_W-1:0] ebc_r, ebc_base, ebc_nxt;
  logic                      fresh;
  logic                      out_valid_r;
  tbd_pkg::res_t             res_r;

  assign q_pop       = q_not_empty && (!out_valid_r || out_ready);
  assign sel         = {q_blk.event_number, q_blk.bunch_crossing};
  assign fresh       = !sel_valid_r || (sel != sel_r);
  assign evt_cnt_nxt = fresh ? evt_cnt_r + 32'd1 : evt_cnt_r;
  assign blk_cnt_nxt = blk_cnt_r + 32'd1;
  assign ebc_base    = fresh ? '0 : ebc_r;
  assign ebc_nxt     = (ebc_base < LIMIT) ? ebc_base + tbd_pkg::CNT_W'(1) : ebc_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      sel_valid_r <= 1'b0;
      evt_cnt_r   <= '0;
      blk_cnt_r   <= '0;
      ebc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        sel_r       <= sel;
        sel_valid_r <= 1'b1;
        evt_cnt_r   <= evt_cnt_nxt;
        blk_cnt_r   <= blk_cnt_nxt;
        ebc_r       <= ebc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r.blk             <= q_blk;
      res_r.new_event       <= fresh;
      res_r.event_total     <= evt_cnt_nxt;
      res_r.block_total     <= blk_cnt_nxt;
      res_r.blocks_in_event <= ebc_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ===== hw/rtl/tracking_block_deframer.sv =====
// Top level of the tracking block deframer.
// Takes one 32-bit readout word per clock. While hunting, words are dropped until one carries
// 0xA in bits 31:28 and 0xC in bits 15:12; that word and the next six form a block, and one
// decoded result leaves per block via the queue and output register. The input rate is one
// word per cycle while the queue has room, set by the front end's assembly path; a two-block
// queue and the output register let the result side stall without stopping input until the
// queue fills. Event tracking and counters update as each block enters the output register.
module tracking_block_deframer #(
  parameter int MAX_BLOCKS_PER_EVENT = 1023
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // word[31:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // bunch_crossing[11:0], event_number[19:12], block_flags[23:20], chip_id[35:24],
  // payload_high[99:36], payload_low[163:100], block_crc[179:164], bx_word[211:180],
  // event_total[243:212], block_total[275:244], blocks_in_event[286:276], zero[287]
  output logic [tbd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [0:0]   out_tuser   // new_event[0]
);

  logic          q_full, q_push, q_pop, q_not_empty;
  tbd_pkg::blk_t push_blk, pop_blk;
  tbd_pkg::res_t res;

  tbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_blk     (push_blk)
  );

  tbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_blk  (push_blk),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_blk   (pop_blk)
  );

  tbd_back #(
    .MAX_BLOCKS_PER_EVENT (MAX_BLOCKS_PER_EVENT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_blk       (pop_blk),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = {1'b0,
                      res.blocks_in_event,
                      res.block_total,
                      res.event_total,
                      res.blk.bx_word,
                      res.blk.block_crc,
                      res.blk.payload_low,
                      res.blk.payload_high,
                      res.blk.chip_id,
                      res.blk.block_flags,
                      res.blk.event_number,
                      res.blk.bunch_crossing};
  assign out_tuser = res.new_event;

endmodule
